[rtl/cpic_pkg.sv]
// ----------------------------------------------------------------------------
// cpic_pkg
// Types and constants shared by the circle clamp core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cpic_pkg;

  localparam int unsigned PosW    = 24;
  localparam int unsigned RadW    = 23;
  localparam int unsigned RootW   = 32;   // floor(sqrt(S * 2^14)) < 2^32
  localparam int unsigned RadicW  = 64;
  localparam int unsigned RemW    = 34;
  localparam int unsigned NumW    = 55;   // (|d| * |limit|) << 7, plus rounding half
  localparam int unsigned QuoW    = 26;   // larger quotients saturate anyway
  localparam int unsigned CmpW    = RootW + QuoW;
  localparam int unsigned ExtraBits = 7;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Z = 2'd1,
    REG_ARENA_R  = 2'd2
  } reg_idx_e;

  // carried alongside the square root cells
  typedef struct packed {
    logic [PosW-1:0] py;
    logic [PosW-1:0] px;
    logic [PosW-1:0] pz;
    logic            clamp;
    logic            negx;
    logic            negz;
    logic [NumW-1:0] nx;
    logic [NumW-1:0] nz;
  } sqrt_side_t;

  // carried alongside the divider cells
  typedef struct packed {
    logic [PosW-1:0] py;
    logic [PosW-1:0] px;
    logic [PosW-1:0] pz;
    logic            clamp;
    logic            negx;
    logic            negz;
    logic            ovfx;
    logic            ovfz;
  } div_side_t;

endpackage

`default_nettype wire

[rtl/cpic_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// cpic_sqrt_cell
// One root digit of the restoring square root; passes data on each cycle that en_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cpic_sqrt_cell (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire  logic [cpic_pkg::RadicW-1:0]   rad_i,
  input  wire  logic [cpic_pkg::RemW-1:0]     rem_i,
  input  wire  logic [cpic_pkg::RootW-1:0]    root_i,
  input  wire  cpic_pkg::sqrt_side_t          side_i,
  output logic [cpic_pkg::RadicW-1:0]         rad_o,
  output logic [cpic_pkg::RemW-1:0]           rem_o,
  output logic [cpic_pkg::RootW-1:0]          root_o,
  output cpic_pkg::sqrt_side_t                side_o
);

  logic [cpic_pkg::RemW+1:0] cur;
  logic [cpic_pkg::RemW+1:0] trial;
  logic                      ge;
  logic [cpic_pkg::RemW+1:0] diff;

  always_comb begin
    cur   = {rem_i, rad_i[cpic_pkg::RadicW-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    ge    = (cur >= trial);
    diff  = cur - trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[cpic_pkg::RadicW-3:0], 2'b00};
      rem_o  <= ge ? diff[cpic_pkg::RemW-1:0] : cur[cpic_pkg::RemW-1:0];
      root_o <= {root_i[cpic_pkg::RootW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

[rtl/cpic_div_cell.sv]
// ----------------------------------------------------------------------------
// cpic_div_cell
// One quotient bit for both axes of the restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cpic_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire  logic [cpic_pkg::RootW-1:0]    r_i,
  input  wire  logic [cpic_pkg::NumW-1:0]     remx_i,
  input  wire  logic [cpic_pkg::NumW-1:0]     remz_i,
  input  wire  logic [cpic_pkg::QuoW-1:0]     qx_i,
  input  wire  logic [cpic_pkg::QuoW-1:0]     qz_i,
  input  wire  cpic_pkg::div_side_t           side_i,
  output logic [cpic_pkg::RootW-1:0]          r_o,
  output logic [cpic_pkg::NumW-1:0]           remx_o,
  output logic [cpic_pkg::NumW-1:0]           remz_o,
  output logic [cpic_pkg::QuoW-1:0]           qx_o,
  output logic [cpic_pkg::QuoW-1:0]           qz_o,
  output cpic_pkg::div_side_t                 side_o
);

  localparam int unsigned PadW = cpic_pkg::CmpW - cpic_pkg::NumW;

  logic [cpic_pkg::CmpW-1:0] dsh;
  logic [cpic_pkg::CmpW-1:0] ex;
  logic [cpic_pkg::CmpW-1:0] ez;
  logic                      gex;
  logic                      gez;
  logic [cpic_pkg::CmpW-1:0] sx;
  logic [cpic_pkg::CmpW-1:0] sz;
  logic [cpic_pkg::QuoW-1:0] qxn;
  logic [cpic_pkg::QuoW-1:0] qzn;

  always_comb begin
    dsh = {{cpic_pkg::QuoW{1'b0}}, r_i} << BIT;
    ex  = {{PadW{1'b0}}, remx_i};
    ez  = {{PadW{1'b0}}, remz_i};
    gex = (ex >= dsh);
    gez = (ez >= dsh);
    sx  = ex - dsh;
    sz  = ez - dsh;
    qxn = qx_i;
    qzn = qz_i;
    qxn[BIT] = gex;
    qzn[BIT] = gez;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o         <= r_i;
      remx_o      <= gex ? sx[cpic_pkg::NumW-1:0] : remx_i;
      remz_o      <= gez ? sz[cpic_pkg::NumW-1:0] : remz_i;
      qx_o        <= qxn;
      qz_o        <= qzn;
      side_o      <= side_i;
    end
  end

endmodule

`default_nettype wire

[rtl/clamp_point_into_circle_core.sv]
// ----------------------------------------------------------------------------
// clamp_point_into_circle_core
// Keeps a point inside a circular arena on the horizontal plane.
// ----------------------------------------------------------------------------
// One request is taken per clock while no result waits at the output; the
// whole pipeline advances together and holds while a result waits at the
// output. The chain is made of three front stages (offsets, products, sum
// and compares), 32 square root cells, a rounding stage, 26 divider cells
// and the output register. A result left waiting at the output holds the
// whole chain and the input with it; throughput is one request per cycle
// while out_ready_i holds.
`default_nettype none

module clamp_point_into_circle_core #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [23:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [23:0] pos_x_i,
  input  wire  [23:0] pos_y_i,
  input  wire  [23:0] pos_z_i,
  input  wire  [22:0] object_radius_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [23:0] out_x_o,
  output logic [23:0] out_y_o,
  output logic [23:0] out_z_o,
  output logic        was_clamped_o
);

  localparam int unsigned NSqrt  = cpic_pkg::RootW;
  localparam int unsigned NDiv   = cpic_pkg::QuoW;
  localparam int unsigned IdxSqr = 3;
  localparam int unsigned IdxPre = IdxSqr + NSqrt;
  localparam int unsigned IdxDiv = IdxPre + 1;
  localparam int unsigned NStg   = IdxDiv + NDiv + 1;
  localparam logic [63:0] ArFull = 64'd2200 << FRAC_BITS;
  localparam logic [63:0] RadMax = 64'd8388607;
  localparam logic [63:0] ArRst  = (ArFull > RadMax) ? RadMax : ArFull;
  localparam logic [63:0] ThrSq  = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;

  // configuration
  logic [23:0] cx_q, cz_q;
  logic [22:0] ar_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cz_q <= '0;
      ar_q <= ArRst[22:0];
    end else if (cfg_valid_i) begin
      unique case (cpic_pkg::reg_idx_e'(cfg_index_i))
        cpic_pkg::REG_CENTER_X: cx_q <= cfg_data_i;
        cpic_pkg::REG_CENTER_Z: cz_q <= cfg_data_i;
        cpic_pkg::REG_ARENA_R:  ar_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            en;
  logic [NStg-1:0] vld_q;

  assign en         = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // stage 1: offsets and limit
  logic signed [24:0] dx_q, dz_q;
  logic [22:0]        alim_q;
  logic               lneg_q;
  logic [23:0]        py1_q, px1_q, pz1_q;
  logic [23:0]        lim_d;

  assign lim_d = {1'b0, ar_q} - {1'b0, object_radius_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= $signed({pos_x_i[23], pos_x_i}) - $signed({cx_q[23], cx_q});
      dz_q   <= $signed({pos_z_i[23], pos_z_i}) - $signed({cz_q[23], cz_q});
      lneg_q <= lim_d[23];
      alim_q <= lim_d[23] ? 23'(-lim_d) : lim_d[22:0];
      py1_q  <= pos_y_i;
      px1_q  <= pos_x_i;
      pz1_q  <= pos_z_i;
    end
  end

  // stage 2: products
  logic [24:0] adx, adz;
  logic [49:0] sqx_q, sqz_q;
  logic [45:0] lsq_q;
  logic [47:0] pxl_q, pzl_q;
  logic        negx2_q, negz2_q;
  logic [23:0] py2_q, px2_q, pz2_q;

  assign adx = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
  assign adz = dz_q[24] ? 25'(-dz_q) : 25'(dz_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q   <= adx * adx;
      sqz_q   <= adz * adz;
      lsq_q   <= alim_q * alim_q;
      pxl_q   <= adx * alim_q;
      pzl_q   <= adz * alim_q;
      negx2_q <= dx_q[24] ^ lneg_q;
      negz2_q <= dz_q[24] ^ lneg_q;
      py2_q   <= py1_q;
      px2_q   <= px1_q;
      pz2_q   <= pz1_q;
    end
  end

  // stage 3: distance squared and clamp decision
  logic [49:0] s_sum;
  logic        far;

  assign s_sum = sqx_q + sqz_q;
  assign far   = (s_sum[49:32] != '0) || ({14'd0, s_sum} > ThrSq);

  logic [cpic_pkg::RadicW-1:0] rad_a  [NSqrt+1];
  logic [cpic_pkg::RemW-1:0]   rem_a  [NSqrt+1];
  logic [cpic_pkg::RootW-1:0]  root_a [NSqrt+1];
  cpic_pkg::sqrt_side_t        sside_a[NSqrt+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_a[0]        <= {s_sum, 14'd0};
      rem_a[0]        <= '0;
      root_a[0]       <= '0;
      sside_a[0].py   <= py2_q;
      sside_a[0].px   <= px2_q;
      sside_a[0].pz   <= pz2_q;
      sside_a[0].clamp <= (s_sum > {4'd0, lsq_q}) && far;
      sside_a[0].negx <= negx2_q;
      sside_a[0].negz <= negz2_q;
      sside_a[0].nx   <= {pxl_q, {cpic_pkg::ExtraBits{1'b0}}};
      sside_a[0].nz   <= {pzl_q, {cpic_pkg::ExtraBits{1'b0}}};
    end
  end

  for (genvar g = 0; g < NSqrt; g++) begin : g_sqrt
    cpic_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_a[g]),
      .rem_i  (rem_a[g]),
      .root_i (root_a[g]),
      .side_i (sside_a[g]),
      .rad_o  (rad_a[g+1]),
      .rem_o  (rem_a[g+1]),
      .root_o (root_a[g+1]),
      .side_o (sside_a[g+1])
    );
  end

  // rounding stage: add half divisor, flag quotients past the divider width
  logic [cpic_pkg::RootW-1:0] r_fin;
  cpic_pkg::sqrt_side_t       sfin;
  logic [cpic_pkg::NumW-1:0]  nxp, nzp;
  logic [cpic_pkg::CmpW-1:0]  rlim;

  assign r_fin = root_a[NSqrt];
  assign sfin  = sside_a[NSqrt];
  assign nxp   = sfin.nx + {{(cpic_pkg::NumW-cpic_pkg::RootW){1'b0}}, r_fin >> 1};
  assign nzp   = sfin.nz + {{(cpic_pkg::NumW-cpic_pkg::RootW){1'b0}}, r_fin >> 1};
  assign rlim  = {r_fin, {cpic_pkg::QuoW{1'b0}}};

  logic [cpic_pkg::RootW-1:0] dr_a  [NDiv+1];
  logic [cpic_pkg::NumW-1:0]  rx_a  [NDiv+1];
  logic [cpic_pkg::NumW-1:0]  rz_a  [NDiv+1];
  logic [cpic_pkg::QuoW-1:0]  qx_a  [NDiv+1];
  logic [cpic_pkg::QuoW-1:0]  qz_a  [NDiv+1];
  cpic_pkg::div_side_t        dside_a[NDiv+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_a[0]          <= r_fin;
      rx_a[0]          <= nxp;
      rz_a[0]          <= nzp;
      qx_a[0]          <= '0;
      qz_a[0]          <= '0;
      dside_a[0].py    <= sfin.py;
      dside_a[0].px    <= sfin.px;
      dside_a[0].pz    <= sfin.pz;
      dside_a[0].clamp <= sfin.clamp;
      dside_a[0].negx  <= sfin.negx;
      dside_a[0].negz  <= sfin.negz;
      dside_a[0].ovfx  <= ({{(cpic_pkg::CmpW-cpic_pkg::NumW){1'b0}}, nxp} >= rlim);
      dside_a[0].ovfz  <= ({{(cpic_pkg::CmpW-cpic_pkg::NumW){1'b0}}, nzp} >= rlim);
    end
  end

  // quotient bits from the top down
  for (genvar g = 0; g < NDiv; g++) begin : g_div
    cpic_div_cell #(
      .BIT (NDiv - 1 - g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .r_i    (dr_a[g]),
      .remx_i (rx_a[g]),
      .remz_i (rz_a[g]),
      .qx_i   (qx_a[g]),
      .qz_i   (qz_a[g]),
      .side_i (dside_a[g]),
      .r_o    (dr_a[g+1]),
      .remx_o (rx_a[g+1]),
      .remz_o (rz_a[g+1]),
      .qx_o   (qx_a[g+1]),
      .qz_o   (qz_a[g+1]),
      .side_o (dside_a[g+1])
    );
  end

  // output stage: centre plus signed offset, saturated
  cpic_pkg::div_side_t       dfin;
  logic [cpic_pkg::QuoW-1:0] qx, qz;
  logic signed [27:0]        sumx, sumz;
  logic [23:0]               satx, satz;

  assign dfin = dside_a[NDiv];
  assign qx   = dfin.ovfx ? '1 : qx_a[NDiv];
  assign qz   = dfin.ovfz ? '1 : qz_a[NDiv];

  always_comb begin
    sumx = $signed({{4{cx_q[23]}}, cx_q})
         + (dfin.negx ? -$signed({2'b00, qx}) : $signed({2'b00, qx}));
    sumz = $signed({{4{cz_q[23]}}, cz_q})
         + (dfin.negz ? -$signed({2'b00, qz}) : $signed({2'b00, qz}));
    if (sumx > 28'sd8388607)       satx = 24'h7fffff;
    else if (sumx < -28'sd8388608) satx = 24'h800000;
    else                           satx = sumx[23:0];
    if (sumz > 28'sd8388607)       satz = 24'h7fffff;
    else if (sumz < -28'sd8388608) satz = 24'h800000;
    else                           satz = sumz[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_o       <= dfin.clamp ? satx : dfin.px;
      out_z_o       <= dfin.clamp ? satz : dfin.pz;
      out_y_o       <= dfin.py;
      was_clamped_o <= dfin.clamp;
    end
  end

  // a clamped request always has distance above 0.001, so the root is at least 128
  a_root_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IdxPre-1] && sfin.clamp |-> r_fin >= 32'd128)
    else $error("clamped request with tiny root");

  // the offset never exceeds about |limit|, well inside the quotient width
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[IdxDiv] && dside_a[1].clamp |-> !dside_a[1].ovfx && !dside_a[1].ovfz)
    else $error("divider quotient overflow on clamped request");

  // an accepted request enters the first stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");

endmodule

`default_nettype wire

[tb/sv/clamp_point_into_circle_core_chk.sv]
// ----------------------------------------------------------------------------
// clamp_point_into_circle_core_chk
// Watches the configuration, request and result channels of the circle clamp
// core, predicts each result from its own copy of the registers and compares
// the results in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module clamp_point_into_circle_core_chk (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [23:0] cfg_data_i,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [23:0] pos_x_i,
  input  wire  [23:0] pos_y_i,
  input  wire  [23:0] pos_z_i,
  input  wire  [22:0] object_radius_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [23:0] out_x_i,
  input  wire  [23:0] out_y_i,
  input  wire  [23:0] out_z_i,
  input  wire         was_clamped_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PosMax = 64'sd8388607;
  localparam longint PosMin = -64'sd8388608;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        clamped;
  } placed_pt_t;

  longint     arena_cx, arena_cz, arena_rad;
  placed_pt_t placed_q[$];

  assign pending_o = placed_q.size();

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   -= res + bit_w;
        res  = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_pos(longint v);
    if (v > PosMax) return PosMax;
    if (v < PosMin) return PosMin;
    return v;
  endfunction

  // offset along one axis: d * limit * 2^7 / root_v, rounded half away from zero
  function automatic longint axis_offset(longint d, longint lim, longint unsigned root_v);
    longint unsigned ad, al, q;
    ad = (d < 0) ? -d : d;
    al = (lim < 0) ? -lim : lim;
    if (root_v == 0) return 0;
    q = (((ad * al) << cpic_pkg::ExtraBits) + (root_v >> 1)) / root_v;
    return ((d < 0) != (lim < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic placed_pt_t place_point(logic [23:0] px_v, logic [23:0] py_v,
                                             logic [23:0] pz_v, logic [22:0] orad);
    placed_pt_t      res;
    longint          px, pz, dx, dz, lim, rx, rz;
    longint unsigned adx, adz, sq, lsq, root_v;
    bit              far_ok;
    px  = longint'(signed'(px_v));
    pz  = longint'(signed'(pz_v));
    dx  = px - arena_cx;
    dz  = pz - arena_cz;
    adx = (dx < 0) ? -dx : dx;
    adz = (dz < 0) ? -dz : dz;
    sq  = adx * adx + adz * adz;
    lim = arena_rad - longint'(orad);
    lsq = ((lim < 0) ? -lim : lim) * ((lim < 0) ? -lim : lim);
    rx  = px;
    rz  = pz;
    res.clamped = 1'b0;
    if (sq > lsq) begin
      // distance must exceed 0.001 units
      far_ok = (sq >= (64'd1 << 32)) || (sq * 1000000 > (64'd1 << 16));
      if (far_ok) begin
        root_v = root_floor(sq << 14);
        rx = sat_pos(arena_cx + axis_offset(dx, lim, root_v));
        rz = sat_pos(arena_cz + axis_offset(dz, lim, root_v));
        res.clamped = 1'b1;
      end
    end
    res.x = rx[23:0];
    res.y = py_v;
    res.z = rz[23:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placed_pt_t want;
    int         errs;
    errs = 0;
    if (!rst_ni) begin
      arena_cx  <= 0;
      arena_cz  <= 0;
      arena_rad <= 2200 << 8;
      fail_cnt_o <= 0;
      placed_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cpic_pkg::REG_CENTER_X: arena_cx  <= longint'(signed'(cfg_data_i));
          cpic_pkg::REG_CENTER_Z: arena_cz  <= longint'(signed'(cfg_data_i));
          cpic_pkg::REG_ARENA_R:  arena_rad <= longint'(cfg_data_i[22:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (placed_q.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = placed_q.pop_front();
          if (out_x_i !== want.x) begin
            $error("out_x: expected %h, got %h", want.x, out_x_i);
            errs++;
          end
          if (out_y_i !== want.y) begin
            $error("out_y: expected %h, got %h", want.y, out_y_i);
            errs++;
          end
          if (out_z_i !== want.z) begin
            $error("out_z: expected %h, got %h", want.z, out_z_i);
            errs++;
          end
          if (was_clamped_i !== want.clamped) begin
            $error("was_clamped: expected %b, got %b", want.clamped, was_clamped_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        placed_q.push_back(place_point(pos_x_i, pos_y_i, pos_z_i, object_radius_i));
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

endmodule

`default_nettype wire

[tb/sv/clamp_point_into_circle_core_tb.sv]
// ----------------------------------------------------------------------------
// clamp_point_into_circle_core_tb
// Drives the circle clamp core through several arena settings with directed
// corner points and random points around the boundary, under random gaps on
// both channels; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module clamp_point_into_circle_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [23:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [22:0] object_radius_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [23:0] out_x_o, out_y_o, out_z_o;
  logic        was_clamped_o;
  int          fail_cnt, pending;
  bit          calm = 1'b0;
  int          cur_cx, cur_cz, cur_rad;

  clamp_point_into_circle_core uut (.*);

  clamp_point_into_circle_core_chk chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .object_radius_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .was_clamped_i(was_clamped_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAIL clamp_point_into_circle_core");
    $finish;
  end

  always @(posedge clk_i)
    out_ready_i <= calm || ($urandom_range(99) >= 29);

  task automatic write_reg(logic [1:0] idx, int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[23:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      cpic_pkg::REG_CENTER_X: cur_cx  = int'(signed'(data[23:0]));
      cpic_pkg::REG_CENTER_Z: cur_cz  = int'(signed'(data[23:0]));
      cpic_pkg::REG_ARENA_R:  cur_rad = int'(data[22:0]);
      default: ;
    endcase
  endtask

  task automatic send_point(int x, int y, int z, int orad);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    in_valid_i      <= 1'b1;
    pos_x_i         <= x[23:0];
    pos_y_i         <= y[23:0];
    pos_z_i         <= z[23:0];
    object_radius_i <= orad[22:0];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic int clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  // points scattered around the limit circle, with some pure noise
  task automatic send_random;
    int  orad, span;
    orad = ($urandom_range(3) == 0) ? (150 << 8) : $urandom_range(cur_rad / 2);
    if ($urandom_range(3) == 0) orad = $urandom_range(23'h7fffff);
    if ($urandom_range(4) == 0) begin
      send_point($urandom, $urandom, $urandom, orad);
    end else begin
      span = (cur_rad < 64) ? 128 : 2 * cur_rad;
      send_point(clip24(longint'(cur_cx) + $urandom_range(2 * span) - span), $urandom,
                 clip24(longint'(cur_cz) + $urandom_range(2 * span) - span), orad);
    end
  endtask

  task automatic settle;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  initial begin
    cur_cx = 0; cur_cz = 0; cur_rad = 2200 << 8;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at the reset arena
    send_point(0, 0, 0, 0);                          // dead centre
    send_point(8388607, 8388607, 8388607, 0);
    send_point(-8388608, -8388608, -8388608, 0);
    send_point(8388607, 1, -8388608, 8388607);       // limit negative
    send_point(1000 << 8, 5, 1000 << 8, 150 << 8);   // inside
    send_point(3000 << 8, 7, -10, 150 << 8);         // outside, camera radius
    send_point(-3000 << 8, 0, 4000 << 8, 0);
    send_point(2200 << 8, 0, 0, 0);                  // exactly on the edge
    send_point(1, 0, 0, 2200 << 8);                  // zero limit, tiny distance
    send_point(0, 0, 0, 2200 << 8);
    send_point(10 << 8, 0, -3, 4000 << 8);
    settle();
    // centre at the corners, radius zero and maximum
    write_reg(cpic_pkg::REG_CENTER_X, 8388607);
    write_reg(cpic_pkg::REG_CENTER_Z, -8388608);
    write_reg(cpic_pkg::REG_ARENA_R, 0);
    write_reg(2'd3, 24'hffffff);                     // unused index
    send_point(-8388608, 3, 8388607, 0);
    send_point(8388607, 3, -8388608, 0);
    send_point(8388607, 3, -8388607, 0);
    send_point(0, 0, 0, 8388607);
    settle();
    write_reg(cpic_pkg::REG_ARENA_R, 8388607);
    send_point(-8388608, 0, 8388607, 0);             // far corner, clamped
    send_point(-8388608, 0, 8388607, 8388607);
    send_point(0, 0, 0, 100);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        write_reg(cpic_pkg::REG_CENTER_X,
                  (ph == 5) ? -8388608 : $urandom_range(2000 << 8) - (1000 << 8));
        write_reg(cpic_pkg::REG_CENTER_Z,
                  (ph == 5) ? 8388607 : $urandom_range(2000 << 8) - (1000 << 8));
        write_reg(cpic_pkg::REG_ARENA_R, (ph == 4) ? 0 : $urandom_range(3000 << 8));
      end else begin
        write_reg(cpic_pkg::REG_CENTER_X, 0);
        write_reg(cpic_pkg::REG_CENTER_Z, 0);
        write_reg(cpic_pkg::REG_ARENA_R, 2200 << 8);
      end
      for (int n = 0; n < 150; n++) begin
        calm = (ph == 2) && (n >= 30) && (n < 130);
        send_random();
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS clamp_point_into_circle_core");
    end else begin
      $display("FAIL clamp_point_into_circle_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
